// File: hdl/sthss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sthss_pkg
// Shared types, codes and constants of the half-step stepper sequencer.
// ----------------------------------------------------------------------------
package sthss_pkg;

   localparam int AMOUNT_W = 16;
   localparam int COUNT_W  = 20;
   localparam int PERIOD_W = 16;
   localparam int PHASE_W  = 3;
   localparam int COILS_W  = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // operation codes
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_STEPS   = 2'd1;
   localparam logic [1:0] OP_DEGREES = 2'd2;
   localparam logic [1:0] OP_TURNS   = 2'd3;

   // degrees to steps: amount*512/45 == (amount * DEG_RECIP) >> DEG_SHIFT,
   // exact over the whole 16-bit amount range
   localparam int          DEG_RECIP_W = 26;
   localparam int          DEG_PROD_W  = AMOUNT_W + DEG_RECIP_W;
   localparam int          DEG_SHIFT   = 22;
   localparam logic [DEG_RECIP_W-1:0] DEG_RECIP = 26'd47721859;

   // command queue entry
   typedef struct packed {
      logic               is_tick;
      logic               direction;
      logic [COUNT_W-1:0] count;
   } cmd_type;

   // result entry
   typedef struct packed {
      logic [COILS_W-1:0] coils;
      logic               busy_res;
      logic               rejected;
   } rsp_type;

   // half-step coil pattern for each phase
   function automatic logic [COILS_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
      logic [COILS_W-1:0] pat;
      case (phase)
         3'd0:    pat = 4'b0001;
         3'd1:    pat = 4'b0011;
         3'd2:    pat = 4'b0010;
         3'd3:    pat = 4'b0110;
         3'd4:    pat = 4'b0100;
         3'd5:    pat = 4'b1100;
         3'd6:    pat = 4'b1000;
         3'd7:    pat = 4'b1001;
         default: pat = 4'b0000;
      endcase
      return pat;
   endfunction

endpackage

// File: hdl/sthss_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sthss_queue
// Small synchronous first-in first-out queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
module sthss_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/sthss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sthss_front
// Accepts requests, sorts ticks from moves and converts move amounts to steps.
// ----------------------------------------------------------------------------
module sthss_front #(
   parameter int STEPS_PER_TURN = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [1:0]                      req_opcode,
   input  logic                            req_direction,
   input  logic [sthss_pkg::AMOUNT_W-1:0]  req_amount,
   output logic                            cmd_push,
   output sthss_pkg::cmd_type              cmd_data,
   input  logic                            cmd_full
);

   import sthss_pkg::*;

   localparam int TURN_W      = $clog2(STEPS_PER_TURN + 1);
   localparam int TURN_PROD_W = AMOUNT_W + TURN_W;

   logic                   valid_ff, valid_in;
   cmd_type                cmd_ff, cmd_in;
   logic                   advance;
   logic [DEG_PROD_W-1:0]  deg_prod;
   logic [TURN_PROD_W-1:0] turn_prod;
   logic [COUNT_W-1:0]     count;

   // stage moves on when empty or when the queue takes its request
   assign advance  = !valid_ff || !cmd_full;
   assign req_full = !advance;
   assign cmd_push = valid_ff && !cmd_full;
   assign cmd_data = cmd_ff;

   // amount to step count
   assign deg_prod  = DEG_PROD_W'(req_amount) * DEG_PROD_W'(DEG_RECIP);
   assign turn_prod = TURN_PROD_W'(req_amount) * TURN_PROD_W'(STEPS_PER_TURN);

   always_comb begin
      case (req_opcode)
         OP_STEPS:   count = COUNT_W'(req_amount);
         OP_DEGREES: count = deg_prod[DEG_SHIFT +: COUNT_W];
         OP_TURNS: begin
            if (turn_prod > TURN_PROD_W'(COUNT_MAX)) begin
               count = COUNT_MAX;
            end else begin
               count = turn_prod[COUNT_W-1:0];
            end
         end
         default:    count = '0;
      endcase
   end

   // classify and hold
   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (advance) begin
         valid_in          = req_push;
         cmd_in.is_tick    = (req_opcode == OP_TICK);
         cmd_in.direction  = req_direction;
         cmd_in.count      = count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule

// File: hdl/sthss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sthss_back
// Runs queued ticks and moves against the motor state and forms results.
// ----------------------------------------------------------------------------
module sthss_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   input  sthss_pkg::cmd_type             cmd_data,
   output logic                           cmd_pop,
   output logic                           rsp_push,
   output sthss_pkg::rsp_type             rsp_data,
   input  logic                           rsp_full,
   input  logic [sthss_pkg::PERIOD_W-1:0] step_period
);

   import sthss_pkg::*;

   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [COUNT_W-1:0]  steps_left_ff, steps_left_in;
   logic [PERIOD_W-1:0] hold_timer_ff, hold_timer_in;
   logic                energized_ff, energized_in;
   logic                move_dir_ff, move_dir_in;
   logic                fire;
   logic                busy;
   logic                rejected;

   assign fire     = cmd_valid && !rsp_full;
   assign cmd_pop  = fire;
   assign rsp_push = fire;
   assign busy     = (steps_left_ff != '0) || energized_ff;

   // next motor state for the request at the queue head
   always_comb begin
      phase_in      = phase_ff;
      steps_left_in = steps_left_ff;
      hold_timer_in = hold_timer_ff;
      energized_in  = energized_ff;
      move_dir_in   = move_dir_ff;
      rejected      = 1'b0;
      if (cmd_data.is_tick) begin
         if (energized_ff) begin
            if (hold_timer_ff != '0) begin
               hold_timer_in = hold_timer_ff - 1'b1;
            end else begin
               energized_in = 1'b0;
            end
         end else if (steps_left_ff != '0) begin
            phase_in      = move_dir_ff ? phase_ff + 1'b1 : phase_ff - 1'b1;
            steps_left_in = steps_left_ff - 1'b1;
            energized_in  = 1'b1;
            hold_timer_in = (step_period == '0) ? '0 : step_period - 1'b1;
         end
      end else if (busy) begin
         rejected = 1'b1;
      end else begin
         steps_left_in = cmd_data.count;
         move_dir_in   = cmd_data.direction;
      end
   end

   // result from the updated state
   always_comb begin
      rsp_data.coils    = energized_in ? coil_pattern(phase_in) : '0;
      rsp_data.busy_res = (steps_left_in != '0) || energized_in;
      rsp_data.rejected = rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         steps_left_ff <= '0;
         hold_timer_ff <= '0;
         energized_ff  <= 1'b0;
         move_dir_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         steps_left_ff <= steps_left_in;
         hold_timer_ff <= hold_timer_in;
         energized_ff  <= energized_in;
         move_dir_ff   <= move_dir_in;
      end
   end

endmodule

// File: hdl/stepper_half_step_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_half_step_sequencer_top
// Half-step sequencer for a four-coil unipolar stepper motor.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_* (push/full): opcode 0 is a one-microsecond tick,
//   opcodes 1..3 load a move in steps, degrees or turns with a direction.
//   Every request yields one result on rsp_* (empty/pop): the coil drive,
//   the busy flag after the request, and a reject flag for a move that
//   arrived while busy.
//   The step period register is written on csr_* (valid/ready, always
//   ready); write it only while no request is in flight.
//   A request passes the front stage and command queue, its result the
//   result queue. While the receiver keeps popping, one request per cycle
//   is sustained: a front stage holds the step conversion multiply, a
//   four-entry queue feeds the back end, and a two-entry result queue lets
//   the receiver pop in every cycle. If the receiver stops popping, the
//   result queue fills, the back end stalls, the command queue and front
//   stage fill, and then req_full rises. Reset clears the motor state and
//   all queues and sets the step period to 1000 ticks.
// ----------------------------------------------------------------------------
module stepper_half_step_sequencer_top #(
   parameter int STEPS_PER_TURN = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [1:0]                     req_opcode,
   input  logic                           req_direction,
   input  logic [sthss_pkg::AMOUNT_W-1:0] req_amount,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [sthss_pkg::COILS_W-1:0]  rsp_coils,
   output logic                           rsp_busy_res,
   output logic                           rsp_rejected,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sthss_pkg::PERIOD_W-1:0] csr_step_period_us
);

   import sthss_pkg::*;

   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   logic [PERIOD_W-1:0] step_period_ff;
   logic                cmd_push;
   cmd_type             cmd_wr;
   logic                cmd_full;
   logic                cmd_pop;
   cmd_type             cmd_rd;
   logic                cmd_empty;
   logic                rsp_push;
   rsp_type             rsp_wr;
   logic                rsp_full;
   rsp_type             rsp_rd;

   // step period register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_period_ff <= PERIOD_W'(1000);
      end else if (csr_valid && csr_ready) begin
         step_period_ff <= csr_step_period_us;
      end
   end

   // request intake and step conversion
   sthss_front #(
      .STEPS_PER_TURN(STEPS_PER_TURN)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_opcode    (req_opcode),
      .req_direction (req_direction),
      .req_amount    (req_amount),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_wr),
      .cmd_full      (cmd_full)
   );

   // decoupling queue between front and back
   sthss_queue #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd),
      .empty     (cmd_empty)
   );

   // motor state and result generation
   sthss_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (!cmd_empty),
      .cmd_data    (cmd_rd),
      .cmd_pop     (cmd_pop),
      .rsp_push    (rsp_push),
      .rsp_data    (rsp_wr),
      .rsp_full    (rsp_full),
      .step_period (step_period_ff)
   );

   // result queue
   sthss_queue #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wr),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_rd),
      .empty     (rsp_empty)
   );

   assign rsp_coils    = rsp_rd.coils;
   assign rsp_busy_res = rsp_rd.busy_res;
   assign rsp_rejected = rsp_rd.rejected;

endmodule
